[hw/rtl/gaussian_blur_5x5_macros.svh]
// Assertion macros used by the blur top level.
`ifndef GAUSSIAN_BLUR_5X5_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define GB5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define GB5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gb5_pkg.sv]
// Shared types, sizes and kernel weights for the 5x5 blur.
package gb5_pkg;

  localparam int KSIZE      = 5;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 12;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = 25;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_DEPTH = 2048;
  localparam int LINE_W     = (KSIZE - 1) * PIX_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = WIDTH_W'(KSIZE);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = WIDTH_W'(LINE_DEPTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = HEIGHT_W'(KSIZE);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = HEIGHT_W'(4096);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST   = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = HEIGHT_W'(480);

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [KSIZE-1:0][PIX_W-1:0]  pix_col_t;
  typedef logic [KSIZE-1:0][COEF_W-1:0] coef_col_t;
  typedef logic [LINE_W-1:0]            line_t;

  typedef struct packed {
    logic shift;     // take the neighbor's column
    logic load_sum;  // register the weighted column sum
  } cell_ctrl_t;

  // Q0.16 weights, row major: index dy*KSIZE + dx
  localparam logic [KSIZE*KSIZE-1:0][COEF_W-1:0] COEF_TAB = {
    12'd1734, 12'd1994, 12'd2204, 12'd2340, 12'd2387,
    12'd1994, 12'd2294, 12'd2535, 12'd2692, 12'd2746,
    12'd2204, 12'd2535, 12'd2802, 12'd2975, 12'd3035,
    12'd2340, 12'd2692, 12'd2975, 12'd3159, 12'd3223,
    12'd2387, 12'd2746, 12'd3035, 12'd3223, 12'd3288
  };

  function automatic coef_col_t coef_column(input int dx);
    coef_col_t c;
    for (int dy = 0; dy < KSIZE; dy++) begin
      c[dy] = COEF_TAB[dy*KSIZE + dx];
    end
    return c;
  endfunction

endpackage

[hw/rtl/gb5_cell.sv]
// One window column: holds five pixels and their weighted sum.
module gb5_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gb5_pkg::cell_ctrl_t ctrl_i,
  input  gb5_pkg::pix_col_t  col_i,
  input  gb5_pkg::coef_col_t coef_i,
  output gb5_pkg::pix_col_t  col_o,
  output logic [gb5_pkg::SUM_W-1:0] psum_o
);
  import gb5_pkg::*;

  pix_col_t          col_q;
  logic [SUM_W-1:0]  psum_d, psum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    psum_d = '0;
    for (int dy = 0; dy < KSIZE; dy++) begin
      psum_d = psum_d + SUM_W'(col_q[dy] * coef_i[dy]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      psum_q <= psum_d;
    end
  end

  assign col_o  = col_q;
  assign psum_o = psum_q;

endmodule

[hw/rtl/gb5_line_store.sv]
// Line store: four earlier rows per column, one write and one registered read.
module gb5_line_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [gb5_pkg::COL_W-1:0] waddr_i,
  input  gb5_pkg::line_t            wdata_i,
  input  logic                      re_i,
  input  logic [gb5_pkg::COL_W-1:0] raddr_i,
  output gb5_pkg::line_t            rdata_o
);
  import gb5_pkg::*;

  line_t mem [LINE_DEPTH];
  line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_data_q;

endmodule

[hw/rtl/gaussian_blur_5x5.sv]
// Top level of the streaming 5x5 blur: counters, line store, cell row, output.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    pixel_in_i
//   out      source     out_valid_o / out_stall_i  pixel_out_o, frame_last_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One pixel beat per cycle while no held output beat stalls the pipe; a result
// passes through the line store read, the cell shift, the column sums and the
// output register, in that order.
// Reset clears counters, window and valid bits; the line store is not cleared.
// A held output beat freezes the whole pipe and raises in_stall_o.
module gaussian_blur_5x5 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gb5_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gb5_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_last_o
);
  import gb5_pkg::*;
  `include "gaussian_blur_5x5_macros.svh"

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic [WIDTH_W-1:0]  width_eff, width_last;
  logic [HEIGHT_W-1:0] height_eff, height_last;

  always_comb begin
    priority if (width_q < WIDTH_MIN) width_eff = WIDTH_MIN;
    else if (width_q > WIDTH_MAX)     width_eff = WIDTH_MAX;
    else                              width_eff = width_q;
    priority if (height_q < HEIGHT_MIN) height_eff = HEIGHT_MIN;
    else if (height_q > HEIGHT_MAX)     height_eff = HEIGHT_MAX;
    else                                height_eff = height_q;
  end

  assign width_last  = width_eff - WIDTH_W'(1);
  assign height_last = height_eff - HEIGHT_W'(1);

  // pipe enable: everything moves unless a held result blocks the output
  logic en, in_acc;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  // position counters
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             last_col, last_row, emit;

  assign last_col = {1'b0, col_q} >= width_last;
  assign last_row = {1'b0, row_q} >= height_last;
  assign emit     = (col_q >= COL_W'(KSIZE - 1)) && (row_q >= ROW_W'(KSIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // stage A: line store read in flight
  logic             va_q, emit_a_q, last_a_q;
  logic [PIX_W-1:0] pix_a_q;
  logic [COL_W-1:0] col_a_q;
  line_t            stored;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_a_q  <= pixel_in_i;
      col_a_q  <= col_q;
      emit_a_q <= emit;
      last_a_q <= last_col && last_row;
    end
  end

  gb5_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (va_q && en),
    .waddr_i (col_a_q),
    .wdata_i ({stored[LINE_W-PIX_W-1:0], pix_a_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (stored)
  );

  // stage B: window shifts in the new column
  logic       vb_q, emit_b_q, last_b_q;
  pix_col_t   new_col;
  cell_ctrl_t cell_ctrl;

  always_comb begin
    for (int dy = 0; dy < KSIZE - 1; dy++) begin
      new_col[dy] = stored[(KSIZE-2-dy)*PIX_W +: PIX_W];
    end
    new_col[KSIZE-1] = pix_a_q;
  end

  assign cell_ctrl.shift    = va_q && en;
  assign cell_ctrl.load_sum = vb_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q && en) begin
      emit_b_q <= emit_a_q;
      last_b_q <= last_a_q;
    end
  end

  pix_col_t         cell_in  [KSIZE];
  pix_col_t         cell_out [KSIZE];
  logic [SUM_W-1:0] psum     [KSIZE];

  for (genvar k = 0; k < KSIZE; k++) begin : g_cell
    if (k == KSIZE - 1) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_link
      assign cell_in[k] = cell_out[k+1];
    end

    gb5_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .col_i  (cell_in[k]),
      .coef_i (coef_column(k)),
      .col_o  (cell_out[k]),
      .psum_o (psum[k])
    );
  end

  // stage C: column sums registered in the cells
  logic vc_q, emit_c_q, last_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q && en) begin
      emit_c_q <= emit_b_q;
      last_c_q <= last_b_q;
    end
  end

  // output: total, round half up, clamp
  logic [SUM_W-1:0]     acc;
  logic [SUM_W-FRAC_W-1:0] rounded;
  logic [PIX_W-1:0]     pix_d, pix_q;
  logic                 last_q;

  always_comb begin
    acc = SUM_W'(1) << (FRAC_W - 1);
    for (int k = 0; k < KSIZE; k++) begin
      acc = acc + psum[k];
    end
    rounded = acc[SUM_W-1:FRAC_W];
    pix_d   = (rounded > (SUM_W-FRAC_W)'(255)) ? PIX_W'(255) : rounded[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vc_q && emit_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vc_q && emit_c_q) begin
      pix_q  <= pix_d;
      last_q <= last_c_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_q;
  assign frame_last_o = last_q;

  `GB5_ASSERT_NEXT(a_col_wrap, in_acc && last_col, col_q == '0, "column count did not wrap")
  `GB5_ASSERT_NEXT(a_col_step, in_acc && !last_col, col_q == $past(col_q) + COL_W'(1), "column count did not advance")
  `GB5_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(vc_q && emit_c_q && en), "result without a window")
  `GB5_ASSERT(a_stall_hold, !en |=> $stable(col_q) && $stable(va_q), "pipe moved while stalled")

endmodule

[tb/tb.sv]
// Self-checking testbench for gaussian_blur_5x5: predicted blurred beats vs. the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb5_pkg::*;

  localparam int WIN          = 5;
  localparam int ROW_SLOTS    = 2048;
  localparam int TALLEST      = 4096;
  localparam int PIPE_SLACK   = 8;
  localparam int LONG_HOLD    = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 850;

  // Q0.16 weights, index dy*WIN + dx, highest index first
  localparam logic [WIN*WIN-1:0][11:0] KERNEL_Q16 = {
    12'd1734, 12'd1994, 12'd2204, 12'd2340, 12'd2387,
    12'd1994, 12'd2294, 12'd2535, 12'd2692, 12'd2746,
    12'd2204, 12'd2535, 12'd2802, 12'd2975, 12'd3035,
    12'd2340, 12'd2692, 12'd2975, 12'd3159, 12'd3223,
    12'd2387, 12'd2746, 12'd3035, 12'd3223, 12'd3288
  };

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } blur_beat_t;

  typedef struct packed {
    logic [7:0] n;
    logic [7:0] pix;
    logic       known;
    blur_beat_t want;
  } dir_row_t;

  typedef enum logic [1:0] {
    FILL_NOISE,
    FILL_FLAT,
    FILL_BINARY
  } fill_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  cfg_idx_e         cfg_idx_i   = CFG_WIDTH;
  logic [12:0]      cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       pixel_in_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       pixel_out_o;
  logic             frame_last_o;

  // predictor state
  logic [11:0]      cfg_width   = 12'd640;
  logic [12:0]      cfg_height  = 13'd480;
  bit   [31:0]      line_mem [ROW_SLOTS];
  bit   [7:0]       win [WIN][WIN];
  int unsigned      col_cnt     = 0;
  int unsigned      row_cnt     = 0;
  int unsigned      cols_seen   = 0;

  blur_beat_t       blurred_q [$];
  blur_beat_t       got_want;
  int               err_count   = 0;
  int               quiet_cycles = 0;
  int unsigned      pixels_fed  = 0;
  bit               idle_on     = 1'b1;
  bit               hold_req    = 1'b0;

  dir_row_t dir_tab [2] = '{
    // white field: first full window is all max, row 4 of 6 so not last
    '{8'd25, 8'hFF, 1'b1, '{8'd255, 1'b0}},
    // black row closes the frame
    '{8'd5,  8'h00, 1'b0, '{8'd0,   1'b0}}
  };

  gaussian_blur_5x5 u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_width();
    if (cfg_width < WIN) return WIN;
    if (cfg_width > ROW_SLOTS) return ROW_SLOTS;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < WIN) return WIN;
    if (cfg_height > TALLEST) return TALLEST;
    return cfg_height;
  endfunction

  // Advance the window by one pixel and form the blurred beat it yields.
  function automatic void blur_pixel(input logic [7:0] pix, output bit emit,
                                     output blur_beat_t res);
    int unsigned w, h, c, acc, val;
    int          dy, dx;
    logic [31:0] held;
    bit          last_c, last_r;
    w      = eff_width();
    h      = eff_height();
    c      = col_cnt % ROW_SLOTS;
    held   = line_mem[c];
    last_c = col_cnt >= w - 1;
    last_r = row_cnt >= h - 1;
    emit   = col_cnt >= WIN - 1 && row_cnt >= WIN - 1;
    for (dy = 0; dy < WIN; dy++)
      for (dx = 0; dx < WIN - 1; dx++)
        win[dy][dx] = win[dy][dx+1];
    for (dy = 0; dy < WIN - 1; dy++)
      win[dy][WIN-1] = held[8*(WIN-2-dy) +: 8];
    win[WIN-1][WIN-1] = pix;
    line_mem[c] = {held[23:0], pix};
    if (c + 1 > cols_seen) cols_seen = c + 1;
    acc = 0;
    for (dy = 0; dy < WIN; dy++)
      for (dx = 0; dx < WIN; dx++)
        acc += KERNEL_Q16[dy*WIN + dx] * win[dy][dx];
    val = (acc + 32'd32768) >> 16;
    if (val > 255) val = 255;
    res.pix  = val[7:0];
    res.last = last_c && last_r;
    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic logic [7:0] pick_pixel(input fill_mode_e mode, input logic [7:0] fill);
    case (mode)
      FILL_FLAT:   return fill;
      FILL_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_WIDTH) cfg_width = val[11:0];
    else cfg_height = val;
  endtask

  // Offer one pixel beat; a known result overrides the prediction.
  task automatic feed(input logic [7:0] pix, input bit known, input blur_beat_t want);
    int         gap;
    bit         emit;
    blur_beat_t res;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    pixels_fed++;
    blur_pixel(pix, emit, res);
    if (emit) blurred_q.push_back(known ? want : res);
  endtask

  task automatic finish_frame(input fill_mode_e mode, input logic [7:0] fill);
    do feed(pick_pixel(mode, fill), 1'b0, '0);
    while (col_cnt != 0 || row_cnt != 0);
  endtask

  // Sender pause: let every pending beat come out, then the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned i, j, base, k, w, h;
    logic [7:0]  fill;
    fill_mode_e  mode;
    bit          held_once;
    held_once = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 5x6 frame, width written below range
    write_reg(CFG_WIDTH, 13'd4);
    write_reg(CFG_HEIGHT, 13'd6);
    for (i = 0; i < 2; i++)
      for (j = 1; j <= dir_tab[i].n; j++)
        feed(dir_tab[i].pix, dir_tab[i].known && j == dir_tab[i].n, dir_tab[i].want);
    drain();

    // widest row: width clamps to 2048, then shrink mid-frame and cut height short
    write_reg(CFG_WIDTH, 13'hFFF);
    write_reg(CFG_HEIGHT, 13'd4096);
    repeat (2100) feed(8'($urandom_range(0, 255)), 1'b0, '0);
    drain();
    write_reg(CFG_WIDTH, 13'd7);
    write_reg(CFG_HEIGHT, 13'd0);
    finish_frame(FILL_NOISE, 8'h00);
    drain();
    write_reg(CFG_WIDTH, 13'd2048);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    repeat (300) feed(8'($urandom_range(0, 255)), 1'b0, '0);
    drain();
    write_reg(CFG_WIDTH, 13'd5);
    write_reg(CFG_HEIGHT, 13'd6);
    finish_frame(FILL_NOISE, 8'h00);
    drain();

    // random small frames, back to back unless the geometry changes
    base = pixels_fed;
    while (pixels_fed - base < RANDOM_ITEMS) begin
      if (pixels_fed - base > RANDOM_ITEMS - 120) idle_on = 1'b0;
      if (pixels_fed == base || $urandom_range(0, 1)) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
        drain();
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
      end
      case ($urandom_range(0, 5))
        0:       mode = FILL_FLAT;
        1:       mode = FILL_BINARY;
        default: mode = FILL_NOISE;
      endcase
      case ($urandom_range(0, 2))
        0:       fill = 8'h00;
        1:       fill = 8'hFF;
        default: fill = 8'($urandom_range(0, 255));
      endcase
      if (!held_once && pixels_fed - base > 300) begin
        hold_req  = 1'b1;
        held_once = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        // geometry change in the middle of a frame
        k = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (k) feed(pick_pixel(mode, fill), 1'b0, '0);
        drain();
        if ($urandom_range(0, 1)) begin
          w = $urandom_range(0, 12);
          if (w > cols_seen) w = cols_seen;
          write_reg(CFG_WIDTH, 13'(w));
        end else begin
          write_reg(CFG_HEIGHT, 13'($urandom_range(0, 9)));
        end
      end
      finish_frame(mode, fill);
    end

    drain();
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // output side back-pressure: short bursts, plus one long hold-off on request
  initial begin : sink_stall
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blurred_q.size() == 0) begin
        $error("unexpected beat: pixel_out %0d frame_last %0b", pixel_out_o, frame_last_o);
        err_count++;
      end else begin
        got_want = blurred_q.pop_front();
        if (pixel_out_o !== got_want.pix) begin
          $error("pixel_out: expected %0d, got %0d", got_want.pix, pixel_out_o);
          err_count++;
        end
        if (frame_last_o !== got_want.last) begin
          $error("frame_last: expected %0b, got %0b", got_want.last, frame_last_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule
